// ===== sv/sha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and round functions of the sha-256 engine
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned QueueDepth = 2;

	localparam logic [7:0] PadByte = 8'h80;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
	} sha_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BYTES,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} sha_state_t;

	localparam logic [255:0] InitHash = {
		32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
		32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
	};

	function automatic logic [31:0] init_word(input logic [2:0] idx);
		init_word = InitHash[idx*32 +: 32];
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k [64];
		k = '{
			32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
			32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
			32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
			32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
			32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
			32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
			32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
			32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
			32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
			32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
			32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
			32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
			32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
			32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
			32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
			32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
		};
		round_k = k[r];
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

// ===== sv/sha_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_front
// input stage and request queue, clamps byte count and drops empty non-last
// ----------------------------------------------------------------------------
module sha_front
	import sha_pkg::*;
#(
	parameter int unsigned DEPTH = QueueDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // msg_word
	input  wire logic [2:0]  s_tuser,   // valid_bytes
	input  wire logic        s_tlast,   // last_word
	output logic             q_valid,
	input  wire logic        q_pop,
	output sha_req_t         q_req
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	sha_req_t    mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic push, keep;
	sha_req_t in_req;

	assign s_tready = (cnt_q != CW'(DEPTH));
	assign keep = s_tlast || (s_tuser != 3'd0);
	assign push = s_tvalid && s_tready && keep;
	always_comb begin
		in_req.word   = s_tdata;
		in_req.nbytes = (s_tuser > 3'd4) ? 3'd4 : s_tuser;
		in_req.last   = s_tlast;
	end
	assign q_valid = (cnt_q != '0);
	assign q_req = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (q_pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CW'(push) - CW'(q_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == CW'(DEPTH)) |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue underflow");
	a_count_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_q == rd_q)) else $error("queue pointers");
endmodule
`default_nettype wire

// ===== sv/sha_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_back
// byte packer, padding sequencer, 64-round compressor and digest output
// ----------------------------------------------------------------------------
module sha_back
	import sha_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	output logic             q_pop,
	input  wire sha_req_t    q_req,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // digest_word
	output logic [2:0]       m_tuser,   // word_index
	output logic             m_tlast    // digest_last
);
	sha_state_t state_q, state_d;
	sha_req_t   cur_q;
	logic [1:0] bi_q;
	logic [63:0] bits_q;
	logic [63:0] len_q;
	logic [5:0] fill_q;
	logic [5:0] rnd_q;
	logic [3:0] padi_q;
	logic       padlen_q;
	logic [31:0] blk_q [16];
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [2:0] oi_q;

	logic [7:0] byte_d, pad_byte;
	logic [31:0] wt, s0, s1, t1, t2, wnew;
	logic [3:0] widx;
	logic byte_go, pad_go, block_full, bytes_done;

	assign byte_d = cur_q.word[(3 - bi_q)*8 +: 8];
	assign pad_byte = padlen_q ? len_q[(7 - padi_q[2:0])*8 +: 8] :
		(padi_q == 4'd0 ? PadByte : 8'h00);
	assign byte_go = (state_q == ST_BYTES);
	assign pad_go = (state_q == ST_PAD);
	assign block_full = (fill_q == 6'd63);
	assign bytes_done = ({1'b0, bi_q} + 3'd1 == cur_q.nbytes);

	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = w_q[0] + s0 + w_q[9] + s1;
		wt = (rnd_q < 6'd16) ? w_q[0] : wnew;
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + wt;
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		widx = fill_q[5:2];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (q_valid) state_d = (q_req.nbytes == 3'd0) ? ST_PAD : ST_BYTES;
			ST_BYTES: begin
				if (block_full) state_d = ST_ROUND;
				else if (bytes_done) state_d = cur_q.last ? ST_PAD : ST_IDLE;
			end
			ST_PAD: begin
				if (block_full) state_d = ST_ROUND;
			end
			ST_ROUND: if (rnd_q == 6'd63) state_d = ST_FOLD;
			ST_FOLD: begin
				if (bi_q == 2'd0 && !padlen_q && padi_q == 4'd0 && !cur_q.last)
					state_d = ST_IDLE;
				else if (padlen_q && padi_q == 4'd8) state_d = ST_EMIT;
				else if (bi_q != 2'd0) state_d = ST_BYTES;
				else if (padi_q != 4'd0 || padlen_q) state_d = ST_PAD;
				else if (cur_q.last) state_d = ST_PAD;
				else state_d = ST_IDLE;
			end
			ST_EMIT: if (m_tready && oi_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == ST_IDLE) && q_valid;
		m_tvalid = (state_q == ST_EMIT);
		m_tdata = h_q[oi_q];
		m_tuser = oi_q;
		m_tlast = (oi_q == 3'd7);
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_req;
		if (byte_go || pad_go)
			blk_q[widx][(3 - fill_q[1:0])*8 +: 8] <= byte_go ? byte_d : pad_byte;
		if (state_q == ST_ROUND) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wt;
		end
		if ((byte_go || pad_go) && block_full) begin
			for (int i = 0; i < 15; i++) w_q[i] <= blk_q[i];
			w_q[15] <= {blk_q[15][31:8], byte_go ? byte_d : pad_byte};
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bi_q <= '0;
			bits_q <= '0;
			len_q <= '0;
			fill_q <= '0;
			rnd_q <= '0;
			padi_q <= '0;
			padlen_q <= 1'b0;
			oi_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_word(3'(i));
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				bi_q <= '0;
				padi_q <= '0;
				padlen_q <= 1'b0;
				if (q_req.nbytes == 3'd0) len_q <= bits_q;
			end
			if (byte_go) begin
				fill_q <= fill_q + 6'd1;
				bits_q <= bits_q + 64'd8;
				if (bytes_done) begin
					bi_q <= '0;
					len_q <= bits_q + 64'd8;
				end else bi_q <= bi_q + 2'd1;
			end
			if (pad_go) begin
				fill_q <= fill_q + 6'd1;
				if (padlen_q) padi_q <= padi_q + 4'd1;
				else if (fill_q == 6'd55) begin
					padlen_q <= 1'b1;
					padi_q <= '0;
				end else padi_q <= 4'd1;
			end
			if (state_q == ST_ROUND) rnd_q <= rnd_q + 6'd1;
			if (state_q == ST_FOLD) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end
			if (state_q == ST_EMIT && m_tready) begin
				oi_q <= oi_q + 3'd1;
				if (oi_q == 3'd7) begin
					for (int i = 0; i < 8; i++) h_q[i] <= init_word(3'(i));
					bits_q <= '0;
					fill_q <= '0;
				end
			end
		end
	end

	a_emit_whole: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && m_tready && oi_q == 3'd7) |=> (state_q == ST_IDLE))
		else $error("digest end");
	a_round_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == 6'd63) |=> (state_q == ST_FOLD && rnd_q == 6'd0))
		else $error("round count");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ST_IDLE)) else $error("pop while busy");
endmodule
`default_nettype wire

// ===== sv/sha256_hash_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit
// sha-256 over big-endian words, eight digest words per message
// ----------------------------------------------------------------------------
// channel  dir  tdata        tuser        tlast
// s_*      in   msg_word     valid_bytes  last_word
// m_*      out  digest_word  word_index   digest_last
// each word is popped from the queue, then packed into the block a byte at a time
// each full block runs through the rounds, then a fold into the hash
// padding is written a byte at a time, then 8 output requests
// asynchronous reset loads the initial hash values, no clearing pass
// a two-entry request queue absorbs input while the back end works
// ----------------------------------------------------------------------------
module sha256_hash_engine_unit
	import sha_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // msg_word
	input  wire logic [2:0]  s_tuser,   // valid_bytes
	input  wire logic        s_tlast,   // last_word
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // digest_word
	output logic [2:0]       m_tuser,   // word_index
	output logic             m_tlast    // digest_last
);
	logic q_valid, q_pop;
	sha_req_t q_req;

	sha_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
		.q_valid, .q_pop, .q_req
	);

	sha_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_req,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
	);
endmodule
`default_nettype wire

// ===== tb/sv/tb_sha256_hash_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_hash_engine_unit
// streams messages of random length and byte fill into the hash engine and
// checks each digest word against a behavioral sha-256 kept in the bench
// ----------------------------------------------------------------------------
module tb_sha256_hash_engine_unit;
	import sha_pkg::*;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
	} msg_req_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_req_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
		logic        known;
		logic [31:0] d0;
	} table_row_t;

	localparam longint unsigned CycleLimit = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	digest_req_t digest_q[$];
	logic [31:0] hash_chain[8];
	logic [31:0] msg_block[16];
	logic [63:0] msg_bits;
	int unsigned msg_fill;
	int          errors = 0;
	longint unsigned cycles = 0;
	bit          calm = 0;
	bit          hold_long = 0;
	bit          stim_done = 0;
	logic [31:0] pinned_d0;
	bit          pinned = 0;

	sha256_hash_engine_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] kconst(input int r);
		logic [31:0] k [64];
		k = '{
			32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
			32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
			32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
			32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
			32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
			32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
			32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
			32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
			32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
			32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
			32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
			32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
			32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
			32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
			32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
			32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
		};
		return k[r];
	endfunction

	task automatic restart_hash();
		hash_chain = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
			32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
		msg_bits = '0;
		msg_fill = 0;
	endtask

	task automatic compress();
		logic [31:0] w[16];
		logic [31:0] v[8];
		logic [31:0] wr, s0, s1, t1, t2, a, b;
		w = msg_block;
		v = hash_chain;
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				wr = w[r];
			end else begin
				a = w[(r - 15) & 15];
				b = w[(r - 2) & 15];
				s0 = ror(a, 7) ^ ror(a, 18) ^ (a >> 3);
				s1 = ror(b, 17) ^ ror(b, 19) ^ (b >> 10);
				wr = w[r & 15] + s0 + w[(r - 7) & 15] + s1;
				w[r & 15] = wr;
			end
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(r) + wr;
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_chain[i] += v[i];
	endtask

	task automatic append_byte(input logic [7:0] b);
		int sh;
		sh = (3 - (msg_fill & 3)) * 8;
		msg_block[msg_fill >> 2] = (msg_block[msg_fill >> 2] & ~(32'hFF << sh))
			| (32'(b) << sh);
		msg_fill++;
		if (msg_fill == 64) begin
			compress();
			msg_fill = 0;
		end
	endtask

	task automatic predict_digest(input msg_req_t rq);
		int n;
		logic [63:0] len;
		digest_req_t d;
		n = (rq.nbytes > 4) ? 4 : rq.nbytes;
		for (int i = 0; i < n; i++) begin
			append_byte(rq.word[31 - 8 * i -: 8]);
			msg_bits += 8;
		end
		if (rq.last) begin
			len = msg_bits;
			append_byte(PadByte);
			while (msg_fill != 56)
				append_byte(8'h00);
			for (int i = 0; i < 8; i++)
				append_byte(len[63 - 8 * i -: 8]);
			if (pinned && hash_chain[0] != pinned_d0) begin
				$error("digest_word 0 table: expected %h actual %h", pinned_d0, hash_chain[0]);
				errors++;
			end
			for (int i = 0; i < 8; i++) begin
				d.word = hash_chain[i];
				d.idx = 3'(i);
				d.last = (i == 7);
				digest_q.push_back(d);
			end
			restart_hash();
		end
	endtask

	task automatic send_req(input msg_req_t rq);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rq.word;
		s_tuser <= rq.nbytes;
		s_tlast <= rq.last;
		do @(posedge clk); while (!s_tready);
		predict_digest(rq);
	endtask

	task automatic send_message(input int words, input bit tidy);
		msg_req_t rq;
		for (int i = 0; i < words; i++) begin
			rq.word = $urandom;
			rq.last = (i == words - 1);
			if (rq.last) rq.nbytes = tidy ? 3'($urandom_range(0, 4)) : 3'($urandom_range(0, 7));
			else if (tidy) rq.nbytes = 3'd4;
			else rq.nbytes = 3'($urandom_range(0, 7));
			send_req(rq);
		end
	endtask

	// receiver with random stalls and one long hold-off
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			if (digest_q.size() == 0) begin
				$error("unexpected digest request %h", m_tdata);
				errors++;
			end else begin
				if (m_tdata !== digest_q[0].word) begin
					$error("digest_word: expected %h actual %h", digest_q[0].word, m_tdata);
					errors++;
				end
				if (m_tuser !== digest_q[0].idx) begin
					$error("word_index: expected %0d actual %0d", digest_q[0].idx, m_tuser);
					errors++;
				end
				if (m_tlast !== digest_q[0].last) begin
					$error("digest_last: expected %0d actual %0d", digest_q[0].last, m_tlast);
					errors++;
				end
				void'(digest_q.pop_front());
			end
		end
	end

	initial begin : rx_stall
		int k;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				m_tready <= 1'b0;
				for (k = 0; k < 600; k++) @(posedge clk);
				hold_long = 0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	table_row_t dir_rows[$];

	initial begin
		msg_req_t rq;
		int drain;
		restart_hash();
		msg_block = '{default: '0};
		// empty message, "abc", zero-byte non-last, oversize counts, partial and full words
		dir_rows = '{
			'{32'h0, 3'd0, 1'b1, 1'b1, 32'hE3B0C442},
			'{32'h61626300, 3'd3, 1'b1, 1'b1, 32'hBA7816BF},
			'{32'hFFFFFFFF, 3'd0, 1'b0, 1'b0, 32'h0},
			'{32'h61626364, 3'd7, 1'b0, 1'b0, 32'h0},
			'{32'h00000000, 3'd5, 1'b0, 1'b0, 32'h0},
			'{32'hFFFFFFFF, 3'd1, 1'b0, 1'b0, 32'h0},
			'{32'h12345678, 3'd2, 1'b0, 1'b0, 32'h0},
			'{32'hA5A5A5A5, 3'd6, 1'b1, 1'b0, 32'h0},
			'{32'hFFFFFFFF, 3'd4, 1'b1, 1'b0, 32'h0},
			'{32'h00000000, 3'd4, 1'b1, 1'b0, 32'h0}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			rq.word = dir_rows[i].word;
			rq.nbytes = dir_rows[i].nbytes;
			rq.last = dir_rows[i].last;
			pinned = dir_rows[i].known;
			pinned_d0 = dir_rows[i].d0;
			send_req(rq);
			pinned = 0;
		end
		// padding boundaries: messages of 52 to 71 bytes, covering 55, 56, 63 and 64
		for (int len = 52; len <= 68; len += 4)
			for (int t = 0; t < 2; t++) begin
				for (int i = 0; i < len / 4; i++) begin
					rq = '{32'($urandom), 3'd4, 1'b0};
					send_req(rq);
				end
				rq = '{32'($urandom), 3'(t * 3), 1'b1};
				send_req(rq);
			end
		// long receiver hold-off while input keeps coming
		hold_long = 1;
		repeat (5) send_message(3, 1);
		// pause until drained
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (digest_q.size() != 0) @(posedge clk);
		for (int m = 0; m < 17; m++)
			send_message($urandom_range(1, 20), $urandom_range(0, 3) != 0);
		calm = 1;
		for (int m = 0; m < 10; m++)
			send_message($urandom_range(1, 8), 1);
		s_tvalid <= 1'b0;
		drain = 0;
		while (digest_q.size() != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (200) @(posedge clk);
		if (errors == 0 && digest_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
